FILE: rtl/core/spq_pkg.sv
// Shared constants, types and command codes of the sorted priority queue.
package spq_pkg;

	// Queue size and key width
	localparam int DEPTH       = 256;
	localparam int WEIGHT_BITS = 32;

	// Fixed port widths
	localparam int SYM_W    = 8;
	localparam int IN_WGT_W = 32;
	localparam int OCC_W    = 9;

	// Width of the fill count, able to hold DEPTH itself
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Command codes
	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	// One stored pair
	typedef struct packed {
		logic [SYM_W-1:0]       symbol;
		logic [WEIGHT_BITS-1:0] weight;
	} entry_t;

	// Operation broadcast to every cell
	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t data;
	} op_t;

	// What the chain reports back to the control
	typedef struct packed {
		entry_t           front;
		logic [CNT_W-1:0] count;
	} chain_stat_t;

endpackage

FILE: rtl/core/spq_cell.sv
// One cell of the sorted chain: holds one pair and moves it left, right or keeps it.
module spq_cell (
	input  logic            clk,
	input  spq_pkg::op_t    op,
	input  logic            occupied,
	input  logic            left_lt,
	input  spq_pkg::entry_t left_entry,
	input  spq_pkg::entry_t right_entry,
	output logic            lt,
	output spq_pkg::entry_t entry
);
	import spq_pkg::*;

	entry_t entry_q;

	// Flag a stored pair that stays ahead of the new one
	assign lt    = occupied && (entry_q.weight < op.data.weight);
	assign entry = entry_q;

	// Keep, take the new pair, take the left neighbor, or take the right neighbor
	always_ff @(posedge clk) begin
		if (op.ins) begin
			if (!lt) begin
				if (left_lt) begin
					entry_q <= op.data;
				end else begin
					entry_q <= left_entry;
				end
			end
		end else if (op.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule

FILE: rtl/core/spq_chain.sv
// Row of queue cells with the fill count; the front of the row is the lowest weight.
module spq_chain (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spq_pkg::op_t         op,
	output spq_pkg::chain_stat_t stat
);
	import spq_pkg::*;

	logic             lt    [DEPTH];
	entry_t           ent   [DEPTH];
	logic [CNT_W-1:0] count_q;

	// Build the row; each cell sees its neighbors and the broadcast operation
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   occ;
		logic   l_lt;
		entry_t l_ent;
		entry_t r_ent;

		assign occ = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign l_lt  = 1'b1;
			assign l_ent = '0;
		end else begin : g_body
			assign l_lt  = lt[i-1];
			assign l_ent = ent[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_ent = '0;
		end else begin : g_link
			assign r_ent = ent[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.op          (op),
			.occupied    (occ),
			.left_lt     (l_lt),
			.left_entry  (l_ent),
			.right_entry (r_ent),
			.lt          (lt[i]),
			.entry       (ent[i])
		);
	end

	// Track the number of stored pairs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (op.ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (op.rem) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign stat.front = ent[0];
	assign stat.count = count_q;

endmodule

FILE: rtl/core/sorted_priority_queue_top.sv
// Sorted priority queue of symbol and weight pairs: control, result register and cell row.
//
// Input channel (in_valid/in_ready): command, symbol, weight. An insert places the pair
// ahead of every stored pair of equal or greater weight; a remove returns the pair of
// lowest weight. Every transaction yields exactly one result transaction.
// Output channel (out_valid/out_ready): out_symbol, out_weight, empty_error, full_error,
// occupancy (pairs stored after the operation).
// The result is registered and shows in the cycle after the input is accepted.
// Throughput: one operation per cycle while the receiver takes each result. The new
// weight is broadcast to every cell and compared there in the same cycle, so the rate is
// set by that compare and the one-step shift of the cell row.
// A stalled receiver holds the result register; a new transaction is still taken in the
// cycle that the held result leaves.
// Reset clears the fill count, so the queue is empty at once; cell contents are not
// cleared and need no clearing pass, since only occupied cells are ever read.
module sorted_priority_queue_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         command,
	input  logic [spq_pkg::SYM_W-1:0]    symbol,
	input  logic [spq_pkg::IN_WGT_W-1:0] weight,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [spq_pkg::SYM_W-1:0]    out_symbol,
	output logic [spq_pkg::IN_WGT_W-1:0] out_weight,
	output logic                         empty_error,
	output logic                         full_error,
	output logic [spq_pkg::OCC_W-1:0]    occupancy
);
	import spq_pkg::*;

	op_t         op;
	chain_stat_t stat;
	logic        accept;
	logic        is_full;
	logic        is_empty;
	logic [CNT_W-1:0] cnt_next;

	logic                   out_valid_q;
	logic [SYM_W-1:0]       out_symbol_q;
	logic [IN_WGT_W-1:0]    out_weight_q;
	logic                   empty_error_q;
	logic                   full_error_q;
	logic [OCC_W-1:0]       occupancy_q;

	// Take a transaction whenever the result register is free or being emptied
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign is_full  = (stat.count == CNT_W'(DEPTH));
	assign is_empty = (stat.count == '0);

	// Decide the operation for the cell row
	always_comb begin
		op.data.symbol = symbol;
		op.data.weight = WEIGHT_BITS'(weight);
		op.ins         = accept && (cmd_t'(command) == CMD_INSERT) && !is_full;
		op.rem         = accept && (cmd_t'(command) == CMD_REMOVE) && !is_empty;
		cnt_next       = stat.count;
		if (op.ins) begin
			cnt_next = stat.count + CNT_W'(1);
		end else if (op.rem) begin
			cnt_next = stat.count - CNT_W'(1);
		end
	end

	spq_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.stat   (stat)
	);

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture the result fields of the accepted transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			out_symbol_q  <= op.rem ? stat.front.symbol : '0;
			out_weight_q  <= op.rem ? IN_WGT_W'(stat.front.weight) : '0;
			empty_error_q <= (cmd_t'(command) == CMD_REMOVE) && is_empty;
			full_error_q  <= (cmd_t'(command) == CMD_INSERT) && is_full;
			occupancy_q   <= OCC_W'(cnt_next);
		end
	end

	assign out_valid   = out_valid_q;
	assign out_symbol  = out_symbol_q;
	assign out_weight  = out_weight_q;
	assign empty_error = empty_error_q;
	assign full_error  = full_error_q;
	assign occupancy   = occupancy_q;

endmodule

FILE: rtl/core/spq_checker.sv
// Port-level checks of the sorted priority queue, bound to the top level.
module spq_sva (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [spq_pkg::SYM_W-1:0]    out_symbol,
	input logic [spq_pkg::IN_WGT_W-1:0] out_weight,
	input logic                         empty_error,
	input logic                         full_error,
	input logic [spq_pkg::OCC_W-1:0]    occupancy
);
	import spq_pkg::*;

	// A failed remove leaves an empty queue and returns no pair
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_error |->
			occupancy == '0 && out_symbol == '0 && out_weight == '0)
		else $error("empty_error with nonempty queue or nonzero pair");

	// A dropped insert leaves a full queue
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && full_error |-> occupancy == OCC_W'(DEPTH) && !empty_error)
		else $error("full_error with queue not full");

	// A result held by the receiver keeps the input side open only as it leaves
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while result register is stalled");

	// A stalled result holds its fields
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_symbol) &&
			$stable(out_weight) && $stable(occupancy))
		else $error("stalled result changed");

endmodule

bind sorted_priority_queue_top spq_sva u_spq_sva (.*);
